// File: rtl/icr_pkg.sv
// Package for the impulse collision response block: payload types, stage map, helpers.
`default_nettype none
package icr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int REST_W = 17;
  localparam logic [REST_W-1:0] REST_RESET = 17'd32768;
  localparam logic [17:0] REST_ONE = 18'd65536;

  typedef struct packed {
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic [30:0]        mass_a;
    logic [30:0]        mass_b;
    logic [1:0]         static_mask;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic signed [31:0] shift_a_x;
    logic signed [31:0] shift_a_y;
    logic signed [31:0] shift_b_x;
    logic signed [31:0] shift_b_y;
  } result_t;

  localparam int ST_IN    = 0;
  localparam int ST_NORM  = 1;
  localparam int ST_SQ    = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_SQRT0 = 4;
  localparam int ST_NUM   = ST_SQRT0 + 32;
  localparam int ST_NDIV0 = ST_NUM + 1;
  localparam int ST_DOT   = ST_NDIV0 + FRAC_BITS + 1;
  localparam int ST_DSUM  = ST_DOT + 1;
  localparam int ST_DABS  = ST_DSUM + 1;
  localparam int ST_SPROD = ST_DABS + 1;
  localparam int ST_S     = ST_SPROD + 1;
  localparam int ST_WPROD = ST_S + 1;
  localparam int ST_WNUM  = ST_WPROD + 1;
  localparam int ST_WDIV0 = ST_WNUM + 1;
  localparam int ST_FPROD = ST_WDIV0 + 53;
  localparam int ST_FMAG  = ST_FPROD + 1;
  localparam int ST_OUT   = ST_FMAG + 1;
  localparam int NST      = ST_OUT + 1;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/icr_if.sv
// Valid/ready channel interfaces for pairs, results and the configuration write.
`default_nettype none
interface icr_pair_if;
  import icr_pkg::*;
  logic  valid;
  logic  ready;
  pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface icr_result_if;
  import icr_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface icr_cfg_if;
  import icr_pkg::*;
  logic              valid;
  logic              ready;
  logic [REST_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/impulse_collision_response.sv
// Top level: fully pipelined impulse collision response for one body pair per beat.
// Throughput: one pair per cycle while the output is not stalled; 117 stages in all.
// The 32-stage square root and the 17- and 53-stage restoring dividers each retire
// one bit per stage, so nothing iterates in place.
// A stalled output freezes every stage together; no beat is lost or repeated.
// Reset clears all stage valid bits and sets restitution to 0.5.
`default_nettype none
module impulse_collision_response (
  input  wire          clk,
  input  wire          rst,
  icr_pair_if.sink     pair_in,
  icr_result_if.source resp_out,
  icr_cfg_if.sink      cfg
);
  import icr_pkg::*;

  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [30:0]        ma;
    logic [30:0]        mb;
    logic [1:0]         smask;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        msum;
    logic               nz;
    logic [31:0]        qx;
    logic [31:0]        qy;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
    logic [63:0]        rad;
    logic [34:0]        srem;
    logic [31:0]        root;
    logic [48:0]        numx;
    logic [48:0]        numy;
    logic [31:0]        remx;
    logic [31:0]        remy;
    logic [16:0]        nxm;
    logic [16:0]        nym;
    logic signed [50:0] pdx;
    logic signed [50:0] pdy;
    logic signed [51:0] d;
    logic [50:0]        dm;
    logic               dneg;
    logic [43:0]        splo;
    logic [42:0]        sphi;
    logic [52:0]        s;
    logic [57:0]        walo;
    logic [56:0]        wahi;
    logic [57:0]        wblo;
    logic [56:0]        wbhi;
    logic [84:0]        na;
    logic [84:0]        nb;
    logic [31:0]        rema;
    logic [31:0]        remb;
    logic [52:0]        wa;
    logic [52:0]        wb;
    logic [43:0]        faxl;
    logic [42:0]        faxh;
    logic [43:0]        fayl;
    logic [42:0]        fayh;
    logic [43:0]        fbxl;
    logic [42:0]        fbxh;
    logic [43:0]        fbyl;
    logic [42:0]        fbyh;
    logic [37:0]        cax;
    logic [37:0]        cay;
    logic [37:0]        cbx;
    logic [37:0]        cby;
    result_t            res;
  } pipe_t;

  pipe_t             st [NST];
  logic [NST-1:0]    vld;
  logic              adv;
  logic [REST_W-1:0] restitution;
  pipe_t             in0;

  assign adv            = !vld[NST-1] || resp_out.ready;
  assign pair_in.ready  = adv;
  assign resp_out.valid = vld[NST-1];
  assign resp_out.data  = st[NST-1].res;
  assign cfg.ready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= REST_RESET;
    end else if (cfg.valid) begin
      restitution <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], pair_in.valid};
    end
  end

  always_comb begin
    in0       = '0;
    in0.vax   = pair_in.data.vel_a_x;
    in0.vay   = pair_in.data.vel_a_y;
    in0.vbx   = pair_in.data.vel_b_x;
    in0.vby   = pair_in.data.vel_b_y;
    in0.px    = pair_in.data.push_x;
    in0.py    = pair_in.data.push_y;
    in0.ma    = pair_in.data.mass_a;
    in0.mb    = pair_in.data.mass_b;
    in0.smask = pair_in.data.static_mask;
    in0.dx    = 33'(pair_in.data.vel_b_x) - 33'(pair_in.data.vel_a_x);
    in0.dy    = 33'(pair_in.data.vel_b_y) - 33'(pair_in.data.vel_a_y);
    in0.msum  = {1'b0, pair_in.data.mass_a} + {1'b0, pair_in.data.mass_b};
    in0.qx    = pair_in.data.push_x[31] ? 32'(-pair_in.data.push_x) : pair_in.data.push_x;
    in0.qy    = pair_in.data.push_y[31] ? 32'(-pair_in.data.push_y) : pair_in.data.push_y;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[ST_IN] <= in0;
    end
  end

  for (genvar g = 1; g < NST; g++) begin : g_stage
    pipe_t c;

    if (g == ST_NORM) begin : g_norm
      always_comb begin
        logic [31:0] m;
        logic [4:0]  top;
        logic [4:0]  sh;
        c = st[g-1];
        m = st[g-1].qx | st[g-1].qy;
        top = '0;
        for (int b = 0; b < 32; b++) begin
          if (m[b]) begin
            top = 5'(b);
          end
        end
        sh = (top == 5'd31) ? 5'd0 : 5'd30 - top;
        c.nz = (m != '0);
        c.qx = st[g-1].qx << sh;
        c.qy = st[g-1].qy << sh;
      end
    end else if (g == ST_SQ) begin : g_sq
      always_comb begin
        c = st[g-1];
        c.sqx = 64'(st[g-1].qx) * 64'(st[g-1].qx);
        c.sqy = 64'(st[g-1].qy) * 64'(st[g-1].qy);
      end
    end else if (g == ST_SUM) begin : g_sum
      always_comb begin
        c = st[g-1];
        c.rad  = st[g-1].sqx + st[g-1].sqy;
        c.srem = '0;
        c.root = '0;
      end
    end else if (g >= ST_SQRT0 && g < ST_NUM) begin : g_sqrt
      localparam int B = 31 - (g - ST_SQRT0);
      always_comb begin
        logic [34:0] r4;
        logic [33:0] trial;
        c = st[g-1];
        r4 = {st[g-1].srem[32:0], st[g-1].rad[2*B+1 -: 2]};
        trial = {st[g-1].root, 2'b01};
        if (r4 >= {1'b0, trial}) begin
          c.srem = r4 - {1'b0, trial};
          c.root = {st[g-1].root[30:0], 1'b1};
        end else begin
          c.srem = r4;
          c.root = {st[g-1].root[30:0], 1'b0};
        end
      end
    end else if (g == ST_NUM) begin : g_num
      always_comb begin
        logic [48:0] nx;
        logic [48:0] ny;
        c = st[g-1];
        nx = {1'b0, st[g-1].qx, {FRAC_BITS{1'b0}}} + 49'(st[g-1].root[31:1]);
        ny = {1'b0, st[g-1].qy, {FRAC_BITS{1'b0}}} + 49'(st[g-1].root[31:1]);
        c.numx = nx;
        c.numy = ny;
        c.remx = nx[48:17];
        c.remy = ny[48:17];
        c.nxm  = '0;
        c.nym  = '0;
      end
    end else if (g >= ST_NDIV0 && g < ST_DOT) begin : g_ndiv
      localparam int B = FRAC_BITS - (g - ST_NDIV0);
      always_comb begin
        logic [32:0] rx;
        logic [32:0] ry;
        logic [32:0] dv;
        c = st[g-1];
        dv = {1'b0, st[g-1].root};
        rx = {st[g-1].remx, st[g-1].numx[B]};
        ry = {st[g-1].remy, st[g-1].numy[B]};
        c.nxm[B] = (rx >= dv);
        c.nym[B] = (ry >= dv);
        c.remx = (rx >= dv) ? 32'(rx - dv) : rx[31:0];
        c.remy = (ry >= dv) ? 32'(ry - dv) : ry[31:0];
      end
    end else if (g == ST_DOT) begin : g_dot
      always_comb begin
        logic [16:0]        mx;
        logic [16:0]        my;
        logic signed [17:0] sx;
        logic signed [17:0] sy;
        c = st[g-1];
        mx = st[g-1].nz ? st[g-1].nxm : '0;
        my = st[g-1].nz ? st[g-1].nym : '0;
        sx = st[g-1].px[31] ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
        sy = st[g-1].py[31] ? -$signed({1'b0, my}) : $signed({1'b0, my});
        c.nxm = mx;
        c.nym = my;
        c.pdx = 51'(st[g-1].dx) * 51'(sx);
        c.pdy = 51'(st[g-1].dy) * 51'(sy);
      end
    end else if (g == ST_DSUM) begin : g_dsum
      always_comb begin
        c = st[g-1];
        c.d = 52'(st[g-1].pdx) + 52'(st[g-1].pdy);
      end
    end else if (g == ST_DABS) begin : g_dabs
      always_comb begin
        c = st[g-1];
        c.dneg = st[g-1].d[51];
        c.dm   = st[g-1].d[51] ? 51'(-st[g-1].d) : st[g-1].d[50:0];
      end
    end else if (g == ST_SPROD) begin : g_sprod
      always_comb begin
        logic [17:0] k;
        c = st[g-1];
        k = REST_ONE + 18'(restitution);
        c.splo = 44'(st[g-1].dm[25:0]) * 44'(k);
        c.sphi = 43'(st[g-1].dm[50:26]) * 43'(k);
      end
    end else if (g == ST_S) begin : g_s
      always_comb begin
        logic [68:0] t;
        c = st[g-1];
        t = {st[g-1].sphi, 26'd0} + 69'(st[g-1].splo) + 69'(32768);
        c.s = t[68:16];
      end
    end else if (g == ST_WPROD) begin : g_wprod
      always_comb begin
        c = st[g-1];
        c.walo = 58'(st[g-1].s[26:0]) * 58'(st[g-1].mb);
        c.wahi = 57'(st[g-1].s[52:27]) * 57'(st[g-1].mb);
        c.wblo = 58'(st[g-1].s[26:0]) * 58'(st[g-1].ma);
        c.wbhi = 57'(st[g-1].s[52:27]) * 57'(st[g-1].ma);
      end
    end else if (g == ST_WNUM) begin : g_wnum
      always_comb begin
        logic [84:0] a;
        logic [84:0] b;
        c = st[g-1];
        a = 85'({st[g-1].wahi, 27'd0}) + 85'(st[g-1].walo) + 85'(st[g-1].msum[31:1]);
        b = 85'({st[g-1].wbhi, 27'd0}) + 85'(st[g-1].wblo) + 85'(st[g-1].msum[31:1]);
        c.na   = a;
        c.nb   = b;
        c.rema = a[84:53];
        c.remb = b[84:53];
        c.wa   = '0;
        c.wb   = '0;
      end
    end else if (g >= ST_WDIV0 && g < ST_FPROD) begin : g_wdiv
      localparam int B = 52 - (g - ST_WDIV0);
      always_comb begin
        logic [32:0] ra;
        logic [32:0] rb;
        logic [32:0] dv;
        c = st[g-1];
        dv = {1'b0, st[g-1].msum};
        ra = {st[g-1].rema, st[g-1].na[B]};
        rb = {st[g-1].remb, st[g-1].nb[B]};
        c.wa[B] = (ra >= dv);
        c.wb[B] = (rb >= dv);
        c.rema = (ra >= dv) ? 32'(ra - dv) : ra[31:0];
        c.remb = (rb >= dv) ? 32'(rb - dv) : rb[31:0];
      end
    end else if (g == ST_FPROD) begin : g_fprod
      always_comb begin
        logic [52:0] a;
        logic [52:0] b;
        c = st[g-1];
        a = (st[g-1].msum == '0) ? '0 : st[g-1].wa;
        b = (st[g-1].msum == '0) ? '0 : st[g-1].wb;
        c.faxl = 44'(a[26:0]) * 44'(st[g-1].nxm);
        c.faxh = 43'(a[52:27]) * 43'(st[g-1].nxm);
        c.fayl = 44'(a[26:0]) * 44'(st[g-1].nym);
        c.fayh = 43'(a[52:27]) * 43'(st[g-1].nym);
        c.fbxl = 44'(b[26:0]) * 44'(st[g-1].nxm);
        c.fbxh = 43'(b[52:27]) * 43'(st[g-1].nxm);
        c.fbyl = 44'(b[26:0]) * 44'(st[g-1].nym);
        c.fbyh = 43'(b[52:27]) * 43'(st[g-1].nym);
      end
    end else if (g == ST_FMAG) begin : g_fmag
      always_comb begin
        logic [69:0] tax;
        logic [69:0] tay;
        logic [69:0] tbx;
        logic [69:0] tby;
        logic [69:0] half;
        c = st[g-1];
        half = 70'(1) << (2*FRAC_BITS - 1);
        tax = {st[g-1].faxh, 27'd0} + 70'(st[g-1].faxl) + half;
        tay = {st[g-1].fayh, 27'd0} + 70'(st[g-1].fayl) + half;
        tbx = {st[g-1].fbxh, 27'd0} + 70'(st[g-1].fbxl) + half;
        tby = {st[g-1].fbyh, 27'd0} + 70'(st[g-1].fbyl) + half;
        c.cax = tax[69:32];
        c.cay = tay[69:32];
        c.cbx = tbx[69:32];
        c.cby = tby[69:32];
      end
    end else if (g == ST_OUT) begin : g_out
      always_comb begin
        logic               xneg;
        logic               yneg;
        logic signed [39:0] ax;
        logic signed [39:0] ay;
        logic signed [39:0] bx;
        logic signed [39:0] by;
        c = st[g-1];
        xneg = st[g-1].dneg ^ st[g-1].px[31];
        yneg = st[g-1].dneg ^ st[g-1].py[31];
        ax = $signed({2'b00, st[g-1].cax});
        ay = $signed({2'b00, st[g-1].cay});
        bx = $signed({2'b00, st[g-1].cbx});
        by = $signed({2'b00, st[g-1].cby});
        ax = xneg ? -ax : ax;
        ay = yneg ? -ay : ay;
        bx = xneg ? bx : -bx;
        by = yneg ? by : -by;
        c.res.new_vel_a_x = st[g-1].smask[0] ? st[g-1].vax : sat32(40'(st[g-1].vax) + ax);
        c.res.new_vel_a_y = st[g-1].smask[0] ? st[g-1].vay : sat32(40'(st[g-1].vay) + ay);
        c.res.new_vel_b_x = st[g-1].smask[1] ? st[g-1].vbx : sat32(40'(st[g-1].vbx) + bx);
        c.res.new_vel_b_y = st[g-1].smask[1] ? st[g-1].vby : sat32(40'(st[g-1].vby) + by);
        c.res.shift_a_x = st[g-1].smask[0] ? '0 : st[g-1].px;
        c.res.shift_a_y = st[g-1].smask[0] ? '0 : st[g-1].py;
        c.res.shift_b_x = st[g-1].smask[1] ? '0 : sat32(-40'(st[g-1].px));
        c.res.shift_b_y = st[g-1].smask[1] ? '0 : sat32(-40'(st[g-1].py));
      end
    end else begin : g_pass
      assign c = st[g-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[g] <= c;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/icr_checker.sv
// Port-level checker for the impulse collision response block, bound to the top level.
`default_nettype none
module icr_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire icr_pkg::result_t out_data,
  input wire                   cfg_ready
);
  import icr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped while stalled.");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("Result payload changed while stalled.");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && cfg_ready)
    else $error("Input held off without a stalled result.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind impulse_collision_response icr_checker u_icr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pair_in.ready),
  .out_valid (resp_out.valid),
  .out_ready (resp_out.ready),
  .out_data  (resp_out.data),
  .cfg_ready (cfg.ready)
);
`default_nettype wire
